/* hdl/impedance_lc_from_phasors_core_macros.svh */
// Assertion macros shared by the impedance core RTL.
`ifndef IMPEDANCE_LC_FROM_PHASORS_CORE_MACROS_SVH
`define IMPEDANCE_LC_FROM_PHASORS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ILCP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("impedance core assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ILCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("impedance core assertion failed");

`endif

/* hdl/ilcp_pkg.sv */
// Shared constants, codes and tables of the impedance core.
package ilcp_pkg;

  localparam int ROTATION_STEPS_DEF = 24;
  localparam int FRACTION_BITS_DEF  = 16;

  // CORDIC angle and vector width
  localparam int ANG_W = 34;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

  localparam logic [1:0] KIND_RES = 2'd0;
  localparam logic [1:0] KIND_IND = 2'd1;
  localparam logic [1:0] KIND_CAP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_CUR  = 2'd1;
  localparam logic [1:0] ST_ZERO_FREQ = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/ilcp_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module ilcp_div_pipe #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QB = 32,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QB-1:0] out_quo,
  output logic          out_ovf,
  output logic [TW-1:0] out_tag
);
  localparam int CW = (NW > DW) ? NW : DW;

  logic [CW-1:0] hi_w;
  logic [CW-1:0] den_w;
  logic [QB:0]   v_r;
  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] lq_r  [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic          ovf_r [QB+1];
  logic [TW-1:0] tag_r [QB+1];

  assign hi_w  = CW'(in_num >> QB);
  assign den_w = CW'(in_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QB-1:0], in_valid};
    end
  end

  // quotient overflows when the top part already reaches the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi_w[DW-1:0];
      lq_r[0]  <= in_num[QB-1:0];
      den_r[0] <= in_den;
      ovf_r[0] <= (hi_w >= den_w);
      tag_r[0] <= in_tag;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    assign trial = {rem_r[k-1], lq_r[k-1][QB-1]};
    assign diff  = trial - {1'b0, den_r[k-1]};
    assign take  = (trial >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
        lq_r[k]  <= {lq_r[k-1][QB-2:0], take};
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign out_valid = v_r[QB];
  assign out_quo   = lq_r[QB];
  assign out_ovf   = ovf_r[QB];
  assign out_tag   = tag_r[QB];

endmodule

/* hdl/ilcp_cordic.sv */
// Pipelined rotation CORDIC, one micro-rotation per stage, plus sign fold.
module ilcp_cordic #(
  parameter int STEPS = 24,
  parameter int TW    = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [ilcp_pkg::ANG_W-1:0]  in_angle,
  input  logic                               in_neg,
  input  logic [TW-1:0]                      in_tag,
  output logic                               out_valid,
  output logic signed [ilcp_pkg::ANG_W-1:0]  out_cos,
  output logic signed [ilcp_pkg::ANG_W-1:0]  out_sin,
  output logic [TW-1:0]                      out_tag
);
  import ilcp_pkg::*;

  logic [STEPS:0]           v_r;
  logic signed [ANG_W-1:0]  x_r   [STEPS];
  logic signed [ANG_W-1:0]  y_r   [STEPS];
  logic signed [ANG_W-1:0]  z_r   [STEPS];
  logic                     neg_r [STEPS];
  logic [TW-1:0]            tag_r [STEPS+1];
  logic signed [ANG_W-1:0]  cos_r;
  logic signed [ANG_W-1:0]  sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEPS-1:0], in_valid};
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [ANG_W-1:0] xa;
    logic signed [ANG_W-1:0] ya;
    logic signed [ANG_W-1:0] za;
    logic signed [ANG_W-1:0] xs;
    logic signed [ANG_W-1:0] ys;
    logic                    na;
    logic [TW-1:0]           ta;

    if (i == 0) begin : g_first
      assign xa = CORDIC_GAIN_INV;
      assign ya = '0;
      assign za = in_angle;
      assign na = in_neg;
      assign ta = in_tag;
    end else begin : g_next
      assign xa = x_r[i-1];
      assign ya = y_r[i-1];
      assign za = z_r[i-1];
      assign na = neg_r[i-1];
      assign ta = tag_r[i-1];
    end

    assign xs = xa >>> i;
    assign ys = ya >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!za[ANG_W-1]) begin
          x_r[i] <= xa - ys;
          y_r[i] <= ya + xs;
          z_r[i] <= za - ANG_W'(atan_turn(i));
        end else begin
          x_r[i] <= xa + ys;
          y_r[i] <= ya - xs;
          z_r[i] <= za + ANG_W'(atan_turn(i));
        end
        neg_r[i] <= na;
        tag_r[i] <= ta;
      end
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r        <= neg_r[STEPS-1] ? -x_r[STEPS-1] : x_r[STEPS-1];
      sin_r        <= neg_r[STEPS-1] ? -y_r[STEPS-1] : y_r[STEPS-1];
      tag_r[STEPS] <= tag_r[STEPS-1];
    end
  end

  assign out_valid = v_r[STEPS];
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;
  assign out_tag   = tag_r[STEPS];

endmodule

/* hdl/impedance_lc_from_phasors_core.sv */
// Top level of the impedance core: phasors in, Z, R, X, L or C and status out.
//
// Usage:
//   Input channel in_*: one request carries voltage and current phasors
//   (magnitude Q16.16, angle in degrees x128) and a frequency in hertz.
//   Output channel out_*: one result per request, in request order, with
//   impedance magnitude and angle, resistance, reactance, inductance or
//   capacitance (Q8.40), load kind and status.
//   Both channels are valid/ready; a request moves when valid and ready meet.
//   Throughput: one request per cycle sustained while the output does not stall.
//   Path: from acceptance to out_valid a request passes S0, the 33-stage
//   magnitude divider, S1 to S3, the CORDIC stages, S4 to S9, the 49-stage
//   component divider and the output register, in series.
//   Stall: the whole pipeline holds while a result waits in the output
//   register; in_ready follows out_ready then, so nothing is lost or repeated.
//   Reset: synchronous, active low, clears all valid bits; no clearing pass.
`include "impedance_lc_from_phasors_core_macros.svh"

module impedance_lc_from_phasors_core #(
  parameter int ROTATION_STEPS = ilcp_pkg::ROTATION_STEPS_DEF,
  parameter int FRACTION_BITS  = ilcp_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_voltage_magnitude,
  input  logic signed [16:0] in_voltage_angle,
  input  logic [31:0]        in_current_magnitude,
  input  logic signed [16:0] in_current_angle,
  input  logic [19:0]        in_frequency_hz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_impedance_magnitude,
  output logic signed [17:0] out_impedance_angle,
  output logic signed [31:0] out_resistance,
  output logic signed [31:0] out_reactance,
  output logic [47:0]        out_component_value,
  output logic [1:0]         out_load_kind,
  output logic [1:0]         out_status
);
  import ilcp_pkg::*;

  // magnitude divider: (V << F + I/2) / I, one extra bit for the rounding carry
  localparam int ZNW = 33 + FRACTION_BITS;
  // component divider widths
  localparam int NUMW_POS = 88 - FRACTION_BITS;
  localparam int NUMW_NEG = 57 + FRACTION_BITS;
  localparam int CNW = ((NUMW_POS > NUMW_NEG) ? NUMW_POS : NUMW_NEG) + 1;
  localparam int CDW = 72;
  localparam int CQB = 48;
  // 100000 << (40 + F): numerator for capacitance, 2 pi taken as 628318/100000
  localparam logic [CNW-1:0] NUM_NEG = CNW'(100000) << (40 + FRACTION_BITS);

  typedef struct packed {
    logic signed [17:0] d;
    logic [19:0]        f;
    logic               imz;
    logic [31:0]        zq;
    logic               zsat;
  } car_t;

  typedef struct packed {
    logic signed [17:0] d;
    logic [19:0]        f;
    logic               imz;
    logic [31:0]        zq;
    logic               zsat;
    logic               satsc;
    logic signed [31:0] r;
    logic signed [31:0] x;
    logic               xz;
    logic               xpos;
  } post_t;

  // Z * |cos| or |sin|, rounded from Q2.30 back to the scale of Z, clamped to signed 32 bits.
  // Result bit 32 flags saturation.
  function automatic logic [32:0] clamp32(input logic [34:0] m, input logic n);
    logic [32:0] res;
    if (!n && (m > 35'h07FFFFFFF)) begin
      res = {1'b1, 32'h7FFFFFFF};
    end else if (n && (m > 35'h080000000)) begin
      res = {1'b1, 32'h80000000};
    end else if (n) begin
      res = {1'b0, 32'(-m)};
    end else begin
      res = {1'b0, m[31:0]};
    end
    return res;
  endfunction

  // global advance: everything moves unless a result sits untaken
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------- S0 input
  logic               s0_v_r;
  logic [31:0]        s0_vm_r;
  logic [31:0]        s0_im_r;
  logic [19:0]        s0_f_r;
  logic signed [17:0] s0_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_vm_r <= in_voltage_magnitude;
      s0_im_r <= in_current_magnitude;
      s0_f_r  <= in_frequency_hz;
      s0_d_r  <= 18'(in_voltage_angle) - 18'(in_current_angle);
    end
  end

  // ---------------------------------------------------- magnitude divider
  car_t           s0_car;
  logic [ZNW-1:0] zdiv_num;
  logic           d1_v;
  logic [31:0]    d1_q;
  logic           d1_ovf;
  logic [$bits(car_t)-1:0] d1_tag;

  always_comb begin
    s0_car      = '0;
    s0_car.d    = s0_d_r;
    s0_car.f    = s0_f_r;
    s0_car.imz  = (s0_im_r == 32'd0);
  end

  assign zdiv_num = (ZNW'(s0_vm_r) << FRACTION_BITS) + ZNW'(s0_im_r >> 1);

  ilcp_div_pipe #(
    .NW(ZNW), .DW(32), .QB(32), .TW($bits(car_t))
  ) u_zdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s0_v_r),
    .in_num   (zdiv_num),
    .in_den   (s0_im_r),
    .in_tag   (s0_car),
    .out_valid(d1_v),
    .out_quo  (d1_q),
    .out_ovf  (d1_ovf),
    .out_tag  (d1_tag)
  );

  // ------------------------------------------ S1 angle wrap and quarter fold
  car_t               d1_car;
  logic signed [17:0] dd;
  logic signed [17:0] dw;
  logic signed [17:0] df;
  logic               fneg;
  car_t               s1_car_nxt;
  logic [13:0]        s1_mag_nxt;

  logic               s1_v_r;
  car_t               s1_car_r;
  logic [13:0]        s1_mag_r;
  logic               s1_zneg_r;
  logic               s1_neg_r;

  assign d1_car = car_t'(d1_tag);
  assign dd     = d1_car.d;

  always_comb begin
    // from (-900, 900] into (-180, 180] degrees
    if (dd > 18'sd69120) begin
      dw = dd - 18'sd92160;
    end else if (dd > 18'sd23040) begin
      dw = dd - 18'sd46080;
    end else if (dd <= -18'sd69120) begin
      dw = dd + 18'sd92160;
    end else if (dd <= -18'sd23040) begin
      dw = dd + 18'sd46080;
    end else begin
      dw = dd;
    end
    // into [-90, 90] degrees, remembering the sign flip
    fneg = 1'b1;
    if (dw > 18'sd11520) begin
      df = dw - 18'sd23040;
    end else if (dw < -18'sd11520) begin
      df = dw + 18'sd23040;
    end else begin
      df   = dw;
      fneg = 1'b0;
    end
    s1_mag_nxt      = df[17] ? 14'(-df) : 14'(df);
    s1_car_nxt      = d1_car;
    s1_car_nxt.zq   = d1_ovf ? 32'hFFFFFFFF : d1_q;
    s1_car_nxt.zsat = d1_ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_car_r  <= s1_car_nxt;
      s1_mag_r  <= s1_mag_nxt;
      s1_zneg_r <= df[17];
      s1_neg_r  <= fneg;
    end
  end

  // ------------------------------------------------- S2 quotient by 45
  // deg*128 -> 2^-32 turn is (mag * 2^22 + 22) / 45; split mag = 45q + r
  logic [28:0] s2_prod;
  logic        s2_v_r;
  car_t        s2_car_r;
  logic [13:0] s2_mag_r;
  logic [8:0]  s2_q_r;
  logic        s2_zneg_r;
  logic        s2_neg_r;

  assign s2_prod = 29'(s1_mag_r) * 29'd23302;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_car_r  <= s1_car_r;
      s2_mag_r  <= s1_mag_r;
      s2_q_r    <= s2_prod[28:20];
      s2_zneg_r <= s1_zneg_r;
      s2_neg_r  <= s1_neg_r;
    end
  end

  // ------------------------------------------- S3 turn angle for CORDIC
  logic [21:0]             frac_tbl [64];
  logic [13:0]             rem45;
  logic signed [ANG_W-1:0] zmag;
  logic                    s3_v_r;
  car_t                    s3_car_r;
  logic signed [ANG_W-1:0] s3_angle_r;
  logic                    s3_neg_r;

  for (genvar k = 0; k < 64; k++) begin : g_frac
    if (k < 45) begin : g_used
      assign frac_tbl[k] = 22'((k * 4194304 + 22) / 45);
    end else begin : g_spare
      assign frac_tbl[k] = '0;
    end
  end

  assign rem45 = s2_mag_r - (14'(s2_q_r) * 14'd45);
  assign zmag  = ANG_W'({s2_q_r, 22'd0}) + ANG_W'(frac_tbl[rem45[5:0]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_car_r   <= s2_car_r;
      s3_angle_r <= s2_zneg_r ? -zmag : zmag;
      s3_neg_r   <= s2_neg_r;
    end
  end

  // ------------------------------------------------------------- CORDIC
  logic                    co_v;
  logic signed [ANG_W-1:0] co_cos;
  logic signed [ANG_W-1:0] co_sin;
  logic [$bits(car_t)-1:0] co_tag;

  ilcp_cordic #(
    .STEPS(ROTATION_STEPS), .TW($bits(car_t))
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s3_v_r),
    .in_angle (s3_angle_r),
    .in_neg   (s3_neg_r),
    .in_tag   (s3_car_r),
    .out_valid(co_v),
    .out_cos  (co_cos),
    .out_sin  (co_sin),
    .out_tag  (co_tag)
  );

  // ------------------------------------------------- S4 Z times cos, sin
  car_t             co_car;
  logic [ANG_W-2:0] cmag;
  logic [ANG_W-2:0] smag;
  logic             s4_v_r;
  car_t             s4_car_r;
  logic [64:0]      s4_pc_r;
  logic [64:0]      s4_ps_r;
  logic             s4_cn_r;
  logic             s4_sn_r;

  assign co_car = car_t'(co_tag);
  assign cmag   = co_cos[ANG_W-1] ? (ANG_W-1)'(-co_cos) : (ANG_W-1)'(co_cos);
  assign smag   = co_sin[ANG_W-1] ? (ANG_W-1)'(-co_sin) : (ANG_W-1)'(co_sin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= co_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_car_r <= co_car;
      s4_pc_r  <= 65'(co_car.zq) * 65'(cmag);
      s4_ps_r  <= 65'(co_car.zq) * 65'(smag);
      s4_cn_r  <= co_cos[ANG_W-1];
      s4_sn_r  <= co_sin[ANG_W-1];
    end
  end

  // ------------------------------------------------- S5 round and clamp
  logic [64:0] pc_rnd;
  logic [64:0] ps_rnd;
  logic [32:0] r_cl;
  logic [32:0] x_cl;
  logic        s5_v_r;
  car_t        s5_car_r;
  logic signed [31:0] s5_r_r;
  logic signed [31:0] s5_x_r;
  logic        s5_satsc_r;

  assign pc_rnd = s4_pc_r + 65'd536870912;
  assign ps_rnd = s4_ps_r + 65'd536870912;
  assign r_cl   = clamp32(pc_rnd[64:30], s4_cn_r);
  assign x_cl   = clamp32(ps_rnd[64:30], s4_sn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_car_r   <= s4_car_r;
      s5_r_r     <= r_cl[31:0];
      s5_x_r     <= x_cl[31:0];
      s5_satsc_r <= r_cl[32] || x_cl[32];
    end
  end

  // --------------------------------------- S6 component operands, 2 pi f
  post_t       s6_post_nxt;
  logic [31:0] ax;
  logic        s6_v_r;
  post_t       s6_post_r;
  logic [39:0] s6_a_r;
  logic [31:0] s6_ax_r;
  logic [48:0] s6_pnum_r;

  assign ax = s5_x_r[31] ? 32'(-s5_x_r) : 32'(s5_x_r);

  always_comb begin
    s6_post_nxt       = '0;
    s6_post_nxt.d     = s5_car_r.d;
    s6_post_nxt.f     = s5_car_r.f;
    s6_post_nxt.imz   = s5_car_r.imz;
    s6_post_nxt.zq    = s5_car_r.zq;
    s6_post_nxt.zsat  = s5_car_r.zsat;
    s6_post_nxt.satsc = s5_satsc_r;
    s6_post_nxt.r     = s5_r_r;
    s6_post_nxt.x     = s5_x_r;
    s6_post_nxt.xz    = (s5_x_r == 32'sd0);
    s6_post_nxt.xpos  = !s5_x_r[31] && (s5_x_r != 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_post_r <= s6_post_nxt;
      s6_a_r    <= 40'(s5_car_r.f) * 40'd628318;
      s6_ax_r   <= ax;
      s6_pnum_r <= 49'(ax) * 49'd100000;
    end
  end

  // ------------------------------------- S7 partial products of 2 pi f |X|
  logic        s7_v_r;
  post_t       s7_post_r;
  logic [39:0] s7_a_r;
  logic [48:0] s7_pnum_r;
  logic [51:0] s7_pl_r;
  logic [51:0] s7_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_post_r <= s6_post_r;
      s7_a_r    <= s6_a_r;
      s7_pnum_r <= s6_pnum_r;
      s7_pl_r   <= 52'(s6_a_r[19:0]) * 52'(s6_ax_r);
      s7_ph_r   <= 52'(s6_a_r[39:20]) * 52'(s6_ax_r);
    end
  end

  // ------------------------------------------------------ S8 divisor
  logic           s8_v_r;
  post_t          s8_post_r;
  logic [48:0]    s8_pnum_r;
  logic [CDW-1:0] s8_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_post_r <= s7_post_r;
      s8_pnum_r <= s7_pnum_r;
      s8_den_r  <= s7_post_r.xpos ? CDW'(s7_a_r)
                                  : (CDW'(s7_ph_r) << 20) + CDW'(s7_pl_r);
    end
  end

  // ---------------------------------------- S9 rounded numerator
  // inductive: X * 2^(40-F) * 100000; capacitive: 100000 * 2^(40+F)
  logic [CNW-1:0] num_sel;
  logic           s9_v_r;
  post_t          s9_post_r;
  logic [CNW-1:0] s9_num_r;
  logic [CDW-1:0] s9_den_r;

  assign num_sel = s8_post_r.xpos ? (CNW'(s8_pnum_r) << (40 - FRACTION_BITS)) : NUM_NEG;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r <= 1'b0;
    end else if (adv) begin
      s9_v_r <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_post_r <= s8_post_r;
      s9_num_r  <= num_sel + CNW'(s8_den_r >> 1);
      s9_den_r  <= s8_den_r;
    end
  end

  // ---------------------------------------------------- component divider
  logic                     d2_v;
  logic [CQB-1:0]           d2_q;
  logic                     d2_ovf;
  logic [$bits(post_t)-1:0] d2_tag;
  post_t                    d2_post;

  ilcp_div_pipe #(
    .NW(CNW), .DW(CDW), .QB(CQB), .TW($bits(post_t))
  ) u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s9_v_r),
    .in_num   (s9_num_r),
    .in_den   (s9_den_r),
    .in_tag   (s9_post_r),
    .out_valid(d2_v),
    .out_quo  (d2_q),
    .out_ovf  (d2_ovf),
    .out_tag  (d2_tag)
  );

  assign d2_post = post_t'(d2_tag);

  // ------------------------------------------------ output register
  logic [31:0]        out_zm_r;
  logic signed [17:0] out_ang_r;
  logic signed [31:0] out_res_r;
  logic signed [31:0] out_reac_r;
  logic [47:0]        out_comp_r;
  logic [1:0]         out_kind_r;
  logic [1:0]         out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d2_v;
    end
  end

  // status priority: zero current, zero frequency (reactive loads only), saturation
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ang_r <= d2_post.d;
      if (d2_post.imz) begin
        out_zm_r     <= 32'hFFFFFFFF;
        out_res_r    <= '0;
        out_reac_r   <= '0;
        out_comp_r   <= '0;
        out_kind_r   <= KIND_RES;
        out_status_r <= ST_ZERO_CUR;
      end else begin
        out_zm_r   <= d2_post.zq;
        out_res_r  <= d2_post.r;
        out_reac_r <= d2_post.x;
        if (d2_post.xz) begin
          // purely resistive
          out_comp_r   <= '0;
          out_kind_r   <= KIND_RES;
          out_status_r <= (d2_post.zsat || d2_post.satsc) ? ST_SAT : ST_OK;
        end else begin
          out_kind_r <= d2_post.xpos ? KIND_IND : KIND_CAP;
          if (d2_post.f == 20'd0) begin
            out_comp_r   <= 48'hFFFFFFFFFFFF;
            out_status_r <= ST_ZERO_FREQ;
          end else begin
            out_comp_r   <= d2_ovf ? 48'hFFFFFFFFFFFF : d2_q;
            out_status_r <= (d2_post.zsat || d2_post.satsc || d2_ovf) ? ST_SAT : ST_OK;
          end
        end
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_impedance_magnitude = out_zm_r;
  assign out_impedance_angle     = out_ang_r;
  assign out_resistance          = out_res_r;
  assign out_reactance           = out_reac_r;
  assign out_component_value     = out_comp_r;
  assign out_load_kind           = out_kind_r;
  assign out_status              = out_status_r;

  // ------------------------------------------------------- assertions
  `ILCP_ASSERT_NEXT(a_req_enters_s0, in_valid && in_ready, s0_v_r)
  `ILCP_ASSERT_IMPL(a_zero_cur_fields, out_valid_r && (out_status_r == ST_ZERO_CUR),
                    (out_zm_r == 32'hFFFFFFFF) && (out_kind_r == KIND_RES))
  `ILCP_ASSERT_IMPL(a_resistive_no_comp, out_valid_r && (out_kind_r == KIND_RES),
                    (out_comp_r == 48'd0) && (out_status_r != ST_ZERO_FREQ))
  `ILCP_ASSERT_IMPL(a_ind_pos_x, out_valid_r && (out_kind_r == KIND_IND),
                    !out_reac_r[31] && (out_reac_r != 32'sd0))
  `ILCP_ASSERT_IMPL(a_cap_neg_x, out_valid_r && (out_kind_r == KIND_CAP), out_reac_r[31])

endmodule
